FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define RMST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequence checked in the cycle after the antecedent
`define RMST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/rmst_pkg.sv
package rmst_pkg;

	localparam logic signed [63:0] MIN_SENTINEL = 64'sh8000_0000_0000_0000;

	localparam logic FUNC_UPDATE = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;

	typedef struct packed {
		logic              func;
		logic [9:0]        index;
		logic [10:0]       right_end;
		logic signed [63:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] max_value;
		logic              found;
	} out_item_t;

	typedef struct packed {
		logic rd_a_en;
		logic rd_b_en;
		logic wr_en;
	} mem_ctl_t;

	function automatic logic signed [63:0] smax(input logic signed [63:0] a,
		input logic signed [63:0] b);
		return (a > b) ? a : b;
	endfunction

endpackage

FILE: design/range_max_segment_tree_core.sv
// update: busy after acceptance until the root is written, one tree level written per cycle
// query: walks the tree from the leaves upward, one level a cycle on two memory read ports
// result sits in an output register; the next transaction is taken while it waits
// P is LEAVES rounded up to a power of two
// after reset a clearing pass writes the minimum sentinel to all 2*P node memory words; input is stalled meanwhile
module range_max_segment_tree_core #(
	parameter int LEAVES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rmst_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output rmst_pkg::out_item_t out_data
);
	import rmst_pkg::*;

	localparam int AW = $clog2(LEAVES) + 1;

	mem_ctl_t           mem_ctl;
	logic [AW-1:0]      wr_addr;
	logic signed [63:0] wr_data;
	logic [AW-1:0]      rd_a_addr;
	logic [AW-1:0]      rd_b_addr;
	logic signed [63:0] rd_a_data;
	logic signed [63:0] rd_b_data;
	logic               res_valid;
	logic               res_ready;
	out_item_t          res_data;
	logic               out_valid_q;
	out_item_t          out_q;

	rmst_node_mem #(
		.AW(AW)
	) u_mem (
		.clk       (clk),
		.ctl       (mem_ctl),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (rd_b_addr),
		.rd_a_data (rd_a_data),
		.rd_b_data (rd_b_data)
	);

	rmst_ctrl #(
		.LEAVES(LEAVES),
		.AW    (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.mem_ctl   (mem_ctl),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (rd_b_addr),
		.rd_a_data (rd_a_data),
		.rd_b_data (rd_b_data)
	);

	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: design/rmst_node_mem.sv
module rmst_node_mem #(
	parameter int AW = 11
) (
	input  logic                clk,
	input  rmst_pkg::mem_ctl_t  ctl,
	input  logic [AW-1:0]       wr_addr,
	input  logic signed [63:0]  wr_data,
	input  logic [AW-1:0]       rd_a_addr,
	input  logic [AW-1:0]       rd_b_addr,
	output logic signed [63:0]  rd_a_data,
	output logic signed [63:0]  rd_b_data
);
	import rmst_pkg::*;

	logic signed [63:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_a_en) begin
			rd_a_data <= mem[rd_a_addr];
		end
		if (ctl.rd_b_en) begin
			rd_b_data <= mem[rd_b_addr];
		end
	end

endmodule

FILE: design/rmst_ctrl.sv
`include "assert_macros.svh"

module rmst_ctrl #(
	parameter int LEAVES = 1024,
	parameter int AW     = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rmst_pkg::in_item_t  in_data,
	output logic                res_valid,
	input  logic                res_ready,
	output rmst_pkg::out_item_t res_data,
	output rmst_pkg::mem_ctl_t  mem_ctl,
	output logic [AW-1:0]       wr_addr,
	output logic signed [63:0]  wr_data,
	output logic [AW-1:0]       rd_a_addr,
	output logic [AW-1:0]       rd_b_addr,
	input  logic signed [63:0]  rd_a_data,
	input  logic signed [63:0]  rd_b_data
);
	import rmst_pkg::*;

	localparam int LVL_W = AW - 1;
	localparam int PW    = AW + 1;
	localparam int CW    = (PW > 11) ? PW : 11;
	localparam logic [AW-1:0] LEAF_BASE = {1'b1, {LVL_W{1'b0}}};
	localparam logic [AW-1:0] ROOT      = AW'(1);
	localparam logic [AW-1:0] CLR_LAST  = {AW{1'b1}};
	localparam logic [CW-1:0] LEAF_CNT  = CW'(LEAVES);

	typedef enum logic [2:0] {
		CLR, IDLE, U_LEAF, U_UP, Q_WALK, Q_D1, Q_D2
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      clr_q;
	logic [AW-1:0]      node_q;
	logic signed [63:0] acc_q;
	logic [PW-1:0]      lo_q;
	logic [PW-1:0]      hi_q;
	logic signed [63:0] best_q;
	logic               va_s1;
	logic               vb_s1;
	logic signed [63:0] pair_s2;

	logic               accept;
	logic [CW-1:0]      idx_ext;
	logic [CW-1:0]      rgt_ext;
	logic [CW-1:0]      rgt_c;
	logic               upd_ok;
	logic               q_ok;
	logic [PW-1:0]      lo_init;
	logic [PW-1:0]      hi_init;
	logic               walk_go;
	logic [PW-1:0]      lo_nxt;
	logic [PW-1:0]      hi_nxt;
	logic [PW-1:0]      hi_m1;
	logic signed [63:0] up_max;
	logic signed [63:0] a_m;
	logic signed [63:0] b_m;

	assign in_stall = (state_q != IDLE);
	assign accept   = in_valid && !in_stall;

	assign idx_ext = CW'(in_data.index);
	assign rgt_ext = CW'(in_data.right_end);
	assign rgt_c   = (rgt_ext > LEAF_CNT) ? LEAF_CNT : rgt_ext;
	assign upd_ok  = idx_ext < LEAF_CNT;
	assign q_ok    = idx_ext < rgt_c;
	assign lo_init = PW'(LEAF_BASE) + PW'(idx_ext);
	assign hi_init = PW'(LEAF_BASE) + PW'(rgt_c);

	assign walk_go = lo_q < hi_q;
	assign lo_nxt  = (lo_q + PW'(lo_q[0])) >> 1;
	assign hi_nxt  = (hi_q - PW'(hi_q[0])) >> 1;
	assign hi_m1   = hi_q - PW'(1);
	assign up_max  = smax(acc_q, rd_a_data);

	assign a_m = va_s1 ? rd_a_data : MIN_SENTINEL;
	assign b_m = vb_s1 ? rd_b_data : MIN_SENTINEL;

	always_comb begin
		mem_ctl   = '0;
		wr_addr   = '0;
		wr_data   = MIN_SENTINEL;
		rd_a_addr = '0;
		rd_b_addr = '0;
		case (state_q)
			CLR: begin
				mem_ctl.wr_en = 1'b1;
				wr_addr       = clr_q;
			end
			U_LEAF: begin
				mem_ctl.wr_en   = 1'b1;
				wr_addr         = node_q;
				wr_data         = acc_q;
				mem_ctl.rd_a_en = 1'b1;
				rd_a_addr       = node_q ^ ROOT;
			end
			U_UP: begin
				mem_ctl.wr_en   = 1'b1;
				wr_addr         = node_q;
				wr_data         = up_max;
				mem_ctl.rd_a_en = (node_q != ROOT);
				rd_a_addr       = node_q ^ ROOT;
			end
			Q_WALK: begin
				mem_ctl.rd_a_en = walk_go && lo_q[0];
				mem_ctl.rd_b_en = walk_go && hi_q[0];
				rd_a_addr       = AW'(lo_q);
				rd_b_addr       = AW'(hi_m1);
			end
			default: begin
			end
		endcase
	end

	// two-level merge of the node pair into the running maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_s1 <= 1'b0;
			vb_s1 <= 1'b0;
		end else begin
			va_s1 <= mem_ctl.rd_b_en | mem_ctl.rd_a_en ? (state_q == Q_WALK) && mem_ctl.rd_a_en
				: 1'b0;
			vb_s1 <= (state_q == Q_WALK) && mem_ctl.rd_b_en;
		end
	end

	always_ff @(posedge clk) begin
		pair_s2 <= smax(a_m, b_m);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLR;
			clr_q   <= '0;
			node_q  <= '0;
			acc_q   <= MIN_SENTINEL;
			lo_q    <= '0;
			hi_q    <= '0;
			best_q  <= MIN_SENTINEL;
		end else begin
			case (state_q)
				CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= IDLE;
					end
				end
				IDLE: begin
					if (accept) begin
						if (in_data.func == FUNC_UPDATE) begin
							if (upd_ok) begin
								node_q  <= LEAF_BASE + AW'(idx_ext);
								acc_q   <= in_data.value;
								state_q <= U_LEAF;
							end
						end else begin
							best_q  <= MIN_SENTINEL;
							lo_q    <= q_ok ? lo_init : '0;
							hi_q    <= q_ok ? hi_init : '0;
							state_q <= Q_WALK;
						end
					end
				end
				U_LEAF: begin
					node_q  <= node_q >> 1;
					state_q <= U_UP;
				end
				U_UP: begin
					acc_q  <= up_max;
					node_q <= node_q >> 1;
					if (node_q == ROOT) begin
						state_q <= IDLE;
					end
				end
				Q_WALK: begin
					best_q <= smax(best_q, pair_s2);
					if (walk_go) begin
						lo_q <= lo_nxt;
						hi_q <= hi_nxt;
					end else begin
						state_q <= Q_D1;
					end
				end
				Q_D1: begin
					best_q  <= smax(best_q, pair_s2);
					state_q <= Q_D2;
				end
				Q_D2: begin
					if (res_ready) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign res_valid          = (state_q == Q_D2);
	assign res_data.max_value = best_q;
	assign res_data.found     = (best_q != MIN_SENTINEL);

	`RMST_ASSERT(a_walk_no_write, (state_q == Q_WALK) |-> !mem_ctl.wr_en, "write during query walk")
	`RMST_ASSERT(a_walk_order, (state_q == Q_WALK) |-> (lo_q <= hi_q), "walk bounds crossed")
	`RMST_ASSERT(a_up_node, (state_q == U_UP) |-> (node_q != '0), "update climbed past root")
	`RMST_ASSERT_NEXT(a_res_idle, res_valid && res_ready, state_q == IDLE, "no return to idle")

endmodule

FILE: tb/rmst_result_checker.sv
`timescale 1ns / 1ps
module rmst_result_checker #(
	parameter int LEAVES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  rmst_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  rmst_pkg::out_item_t out_data,
	output int                  fail_count,
	output int                  outstanding
);
	import rmst_pkg::*;

	logic signed [63:0] leaf_shadow [LEAVES];
	out_item_t pending_answers [$];
	int failures;

	assign fail_count = failures;

	function automatic out_item_t leaf_range_max(input int unsigned lo, input int unsigned hi);
		out_item_t ans;
		logic signed [63:0] best;
		int unsigned stop;
		best = MIN_SENTINEL;
		stop = (hi > LEAVES) ? LEAVES : hi;
		for (int unsigned k = lo; k < stop; k++) begin
			if (leaf_shadow[k] > best) begin
				best = leaf_shadow[k];
			end
		end
		ans.max_value = best;
		ans.found = (best != MIN_SENTINEL);
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			foreach (leaf_shadow[k]) begin
				leaf_shadow[k] = MIN_SENTINEL;
			end
			pending_answers.delete();
			failures = 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_answers.size() == 0) begin
					$error("result with no query waiting: max_value %0d, found %0b",
						$signed(out_data.max_value), out_data.found);
					failures++;
				end else begin
					want = pending_answers.pop_front();
					if (out_data.max_value !== want.max_value) begin
						$error("max_value: expected %0d, got %0d",
							$signed(want.max_value), $signed(out_data.max_value));
						failures++;
					end
					if (out_data.found !== want.found) begin
						$error("found: expected %0b, got %0b", want.found, out_data.found);
						failures++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (in_data.func == FUNC_UPDATE) begin
					if (in_data.index < LEAVES) begin
						leaf_shadow[in_data.index] = in_data.value;
					end
				end else begin
					pending_answers.push_back(leaf_range_max(in_data.index, in_data.right_end));
				end
			end
			outstanding <= pending_answers.size();
		end
	end

endmodule

FILE: tb/tb_range_max_segment_tree_core.sv
`timescale 1ns / 1ps
module tb_range_max_segment_tree_core;
	import rmst_pkg::*;

	localparam int LEAVES = 1024;
	localparam int RANDOM_ITEMS = 400;
	localparam int QUIET_ITEMS = 60;
	localparam int STALL_LIMIT = 20000;
	localparam logic signed [63:0] MAX_POS = 64'sh7fff_ffff_ffff_ffff;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	logic      quiet;
	int        fail_count;
	int        outstanding;

	range_max_segment_tree_core #(
		.LEAVES(LEAVES)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	rmst_result_checker #(
		.LEAVES(LEAVES)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic in_item_t make_item(input logic f, input int unsigned idx,
		input int unsigned re, input logic signed [63:0] v);
		in_item_t it;
		it.func = f;
		it.index = idx[9:0];
		it.right_end = re[10:0];
		it.value = v;
		return it;
	endfunction

	function automatic logic signed [63:0] pick_value();
		case ($urandom_range(0, 5))
			0: begin
				return MIN_SENTINEL;
			end
			1: begin
				return MAX_POS;
			end
			2: begin
				return $signed({32'd0, 32'($urandom_range(0, 200))}) - 64'sd100;
			end
			default: begin
				return {$urandom, $urandom};
			end
		endcase
	endfunction

	task automatic send(input in_item_t item);
		@(negedge clk);
		in_valid = 1'b1;
		in_data = item;
		do @(posedge clk); while (in_stall);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(0, 10)) @(negedge clk);
		end
	endtask

	task automatic wait_for_answers();
		@(negedge clk);
		in_valid = 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// result side back-pressure
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("range_max_segment_tree_core: mismatch");
		$finish;
	end

	initial begin
		int unsigned lo;
		int unsigned re;
		int unsigned span;
		quiet = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		send(make_item(FUNC_QUERY, 0, LEAVES, 0));
		send(make_item(FUNC_QUERY, 0, 2047, MAX_POS));
		send(make_item(FUNC_UPDATE, 0, 2047, MAX_POS));
		send(make_item(FUNC_UPDATE, LEAVES - 1, 0, -64'sd1));
		send(make_item(FUNC_UPDATE, 512, 0, MIN_SENTINEL));
		send(make_item(FUNC_QUERY, 512, 513, 0));
		send(make_item(FUNC_QUERY, 0, 1, 0));
		send(make_item(FUNC_QUERY, LEAVES - 1, LEAVES, 0));
		send(make_item(FUNC_QUERY, LEAVES - 1, 2047, 0));
		send(make_item(FUNC_QUERY, 700, 5, 0));
		send(make_item(FUNC_QUERY, 300, 300, 0));
		send(make_item(FUNC_QUERY, LEAVES - 1, LEAVES - 1, 0));
		send(make_item(FUNC_QUERY, 0, 0, 0));
		send(make_item(FUNC_QUERY, 1, 2047, 0));
		send(make_item(FUNC_UPDATE, 0, 0, MIN_SENTINEL));
		send(make_item(FUNC_QUERY, 0, LEAVES, 0));
		send(make_item(FUNC_UPDATE, 5, 1234, 64'sd0));
		send(make_item(FUNC_QUERY, 0, 10, 0));
		send(make_item(FUNC_UPDATE, 700, 1500, 64'sd1));
		send(make_item(FUNC_QUERY, 511, LEAVES, 0));
		send(make_item(FUNC_QUERY, 0, 2047, 0));
		send(make_item(FUNC_QUERY, 513, 700, 0));
		wait_for_answers();

		// mostly a narrow window so that queries see many written leaves
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet = (i >= RANDOM_ITEMS - QUIET_ITEMS);
			if (i == RANDOM_ITEMS / 2) begin
				wait_for_answers();
			end
			span = ($urandom_range(0, 4) < 3) ? 63 : LEAVES - 1;
			lo = $urandom_range(0, span);
			if ($urandom_range(0, 1) == 0) begin
				send(make_item(FUNC_UPDATE, lo, $urandom_range(0, 2047), pick_value()));
			end else begin
				case ($urandom_range(0, 3))
					0: begin
						re = lo + $urandom_range(0, 40);
					end
					1: begin
						re = $urandom_range(0, 2047);
					end
					2: begin
						re = LEAVES;
					end
					default: begin
						re = $urandom_range(lo, span + 1);
					end
				endcase
				send(make_item(FUNC_QUERY, lo, re, pick_value()));
			end
		end

		wait_for_answers();
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("range_max_segment_tree_core: match");
		end else begin
			$display("range_max_segment_tree_core: mismatch");
		end
		$finish;
	end

endmodule
